// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When trig holds, expr holds in the following clock cycle.
`define ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

// ----- design/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Constants, types and the alphabet lookup for the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int LINE_LENGTH_DEF = 76;
  localparam int COL_W           = 7;   // column counter width
  localparam int MAX_CHARS       = 6;   // most characters one item can produce
  localparam int CNT_W           = 3;   // holds 1..MAX_CHARS

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  // Characters produced by one item, in output order.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
  } b64e_burst_t;

  // Standard base64 alphabet.
  function automatic logic [7:0] b64_sym(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26)       return wide + 8'd65;  // 'A'..
    else if (idx < 6'd52)  return wide + 8'd71;  // 'a'..
    else if (idx < 6'd62)  return wide - 8'd4;   // '0'..
    else if (idx == 6'd62) return 8'h2B;         // '+'
    else                   return 8'h2F;         // '/'
  endfunction

endpackage

// ----- design/b64e_in_if.sv -----
// ----------------------------------------------------------------------------
// b64e_in_if
// Input channel: one raw byte per item with a final-byte mark.
// ----------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- design/b64e_out_if.sv -----
// ----------------------------------------------------------------------------
// b64e_out_if
// Result channel: one ASCII character per item, last mark per input item.
// ----------------------------------------------------------------------------
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- design/base64_stream_encoder_top.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder with optional CR LF line breaks.
// ----------------------------------------------------------------------------
// Each input item is one raw byte; the block answers with its base64
// characters one per cycle while the result channel is ready, last_of_run
// marking the final character of that byte. A byte produces 1 to 6
// characters (pads and CR LF included) and holds the output port until its
// last character is taken. The next byte is taken in the cycle its
// predecessor's last character leaves, so there is no gap between bursts.
// cfg_wdata, written with cfg_we while idle, enables line breaks every
// LINE_LENGTH characters (rounded up to a multiple of 4) and at the end of a
// message.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int LINE_LENGTH = b64e_pkg::LINE_LENGTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  b64e_in_if.sink    in_stream,
  b64e_out_if.source out_stream
);
  import b64e_pkg::*;

  logic             lbe_r;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  b64e_burst_t      burst_r, burst_nxt;
  b64e_burst_t      core_burst;

  logic is_last;
  logic out_fire;
  logic last_fire;
  logic in_fire;

  b64e_core #(.LINE_LENGTH(LINE_LENGTH)) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (in_fire),
    .data_byte         (in_stream.data_byte),
    .final_byte        (in_stream.final_byte),
    .line_break_enable (lbe_r),
    .burst             (core_burst)
  );

  assign is_last   = (idx_r == burst_r.count - 1'b1);
  assign out_fire  = busy_r && out_stream.ready;
  assign last_fire = out_fire && is_last;
  assign in_stream.ready = !busy_r || last_fire;
  assign in_fire   = in_stream.valid && in_stream.ready;

  assign out_stream.valid       = busy_r;
  assign out_stream.out_char    = burst_r.chars[idx_r];
  assign out_stream.last_of_run = is_last;

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    burst_nxt = burst_r;
    if (in_fire) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      burst_nxt = core_burst;
    end else if (last_fire) begin
      busy_nxt = 1'b0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lbe_r  <= 1'b0;
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (cfg_we) lbe_r <= cfg_wdata;
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_count_nonzero, !busy_r || (burst_r.count != '0), "empty burst held")
  `ASSERT_CLK(a_idx_in_range, !busy_r || (idx_r < burst_r.count), "char index past burst")
  `ASSERT_NEXT(a_accept_busy, in_fire, busy_r && (idx_r == '0), "accepted item not held")
  `ASSERT_NEXT(a_last_frees, last_fire && !in_fire, !busy_r, "buffer not freed after last")

endmodule

// ----- design/b64e_core.sv -----
// ----------------------------------------------------------------------------
// b64e_core
// Encoder state (carry bits, group phase, line column) and the character
// burst that one input byte produces.
// ----------------------------------------------------------------------------
module b64e_core #(
  parameter int LINE_LENGTH = b64e_pkg::LINE_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  input  logic                  line_break_enable,
  output b64e_pkg::b64e_burst_t burst
);
  import b64e_pkg::*;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  localparam logic [COL_W-1:0] LINE_LEN = COL_W'(LINE_LENGTH);

  logic [3:0]       carry_r, carry_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  always_comb begin
    logic [CNT_W-1:0] n;
    logic             group_done;
    logic [COL_W-1:0] col_sum;
    n          = '0;
    group_done = 1'b0;
    burst      = '0;
    col_nxt    = col_r;
    col_sum    = col_r + COL_W'(4);

    if (phase_r == PH_0) begin
      burst.chars[n] = b64_sym(data_byte[7:2]);
      n = n + 1'b1;
      carry_nxt = {2'b00, data_byte[1:0]};
      phase_nxt = PH_1;
    end else if (phase_r == PH_1) begin
      burst.chars[n] = b64_sym({carry_r[1:0], data_byte[7:4]});
      n = n + 1'b1;
      carry_nxt = data_byte[3:0];
      phase_nxt = PH_2;
    end else begin
      // phase 2, and the unused code 3 behaves the same
      burst.chars[n] = b64_sym({carry_r, data_byte[7:6]});
      n = n + 1'b1;
      burst.chars[n] = b64_sym(data_byte[5:0]);
      n = n + 1'b1;
      carry_nxt  = '0;
      phase_nxt  = PH_0;
      group_done = 1'b1;
    end

    // flush a partial group with pads
    if (final_byte) begin
      if (phase_nxt == PH_1) begin
        burst.chars[n] = b64_sym({carry_nxt[1:0], 4'b0000});
        n = n + 1'b1;
        burst.chars[n] = CHAR_PAD;
        n = n + 1'b1;
        burst.chars[n] = CHAR_PAD;
        n = n + 1'b1;
        group_done = 1'b1;
      end else if (phase_nxt == PH_2) begin
        burst.chars[n] = b64_sym({carry_nxt, 2'b00});
        n = n + 1'b1;
        burst.chars[n] = CHAR_PAD;
        n = n + 1'b1;
        group_done = 1'b1;
      end
    end

    // column is checked only at whole 4-character groups
    if (group_done && line_break_enable) begin
      if (col_sum >= LINE_LEN) begin
        burst.chars[n] = CHAR_CR;
        n = n + 1'b1;
        burst.chars[n] = CHAR_LF;
        n = n + 1'b1;
        col_nxt = '0;
      end else begin
        col_nxt = col_sum;
      end
    end

    if (final_byte) begin
      if (line_break_enable && (col_nxt != '0)) begin
        burst.chars[n] = CHAR_CR;
        n = n + 1'b1;
        burst.chars[n] = CHAR_LF;
        n = n + 1'b1;
      end
      carry_nxt = '0;
      phase_nxt = PH_0;
      col_nxt   = '0;
    end

    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
      phase_r <= PH_0;
      col_r   <= '0;
    end else if (advance) begin
      carry_r <= carry_nxt;
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the base64 stream encoder against a cycle-free encoding predictor.
// A short table of directed bytes runs first, several rows with typed-in
// character strings. Random messages follow: short and long ones, line breaks
// toggled between and within messages, random gaps and stalls on both
// channels, and one long output hold-off that backs up the input channel.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LINE_LEN     = b64e_pkg::LINE_LENGTH_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 8;
  localparam int WATCHDOG     = 1000;
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  data;     // byte, or register value for a config row
    logic        fin;
    int          pin_n;    // 0: predictor decides
    logic [47:0] pin;      // typed characters, right-justified
  } stim_row_t;

  // Characters of one input item, right-justified, first character highest.
  typedef struct packed {
    logic [47:0] chars;
    logic [2:0]  count;
  } char_burst_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_stream_encoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  always #5 clk = ~clk;

  // encoder shadow state
  logic        lb_on;
  logic [3:0]  carry;
  logic [1:0]  grp_phase;
  logic [6:0]  column;

  out_char_t   pending_chars[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          pin_count;
  logic [47:0] pin_chars;
  bit          hold_req = 1'b0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  int          fast_left = 0;

  function automatic logic [7:0] alpha(input logic [5:0] idx);
    return B64_ALPHABET[8*(63-idx) +: 8];
  endfunction

  function automatic char_burst_t add_char(input char_burst_t r, input logic [7:0] c);
    r.chars = {r.chars[39:0], c};
    r.count = r.count + 3'd1;
    return r;
  endfunction

  function automatic char_burst_t encode_byte(input logic [7:0] b, input logic fin);
    char_burst_t r;
    logic        group_done;
    r = '0;
    group_done = 1'b0;
    case (grp_phase)
      2'd0: begin
        r = add_char(r, alpha(b[7:2]));
        carry = {2'b00, b[1:0]};
        grp_phase = 2'd1;
      end
      2'd1: begin
        r = add_char(r, alpha({carry[1:0], b[7:4]}));
        carry = b[3:0];
        grp_phase = 2'd2;
      end
      default: begin
        r = add_char(r, alpha({carry, b[7:6]}));
        r = add_char(r, alpha(b[5:0]));
        carry = '0;
        grp_phase = 2'd0;
        group_done = 1'b1;
      end
    endcase
    if (fin) begin
      if (grp_phase == 2'd1) begin
        r = add_char(r, alpha({carry[1:0], 4'b0000}));
        r = add_char(r, b64e_pkg::CHAR_PAD);
        r = add_char(r, b64e_pkg::CHAR_PAD);
        group_done = 1'b1;
      end else if (grp_phase == 2'd2) begin
        r = add_char(r, alpha({carry, 2'b00}));
        r = add_char(r, b64e_pkg::CHAR_PAD);
        group_done = 1'b1;
      end
    end
    // column only moves on whole 4-char groups
    if (group_done && lb_on) begin
      column = column + 7'd4;
      if (column >= LINE_LEN) begin
        r = add_char(r, b64e_pkg::CHAR_CR);
        r = add_char(r, b64e_pkg::CHAR_LF);
        column = '0;
      end
    end
    if (fin) begin
      if (lb_on && column != 0) begin
        r = add_char(r, b64e_pkg::CHAR_CR);
        r = add_char(r, b64e_pkg::CHAR_LF);
      end
      carry = '0;
      grp_phase = '0;
      column = '0;
    end
    return r;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // Accepted items on both channels, predictor update and watchdog.
  always @(posedge clk) begin : scoreboard
    logic        in_acc;
    logic        out_acc;
    char_burst_t burst;
    out_char_t   want;
    int          i;
    if (rst_n !== 1'b1) begin
      lb_on = 1'b0;
      carry = '0;
      grp_phase = '0;
      column = '0;
      idle_cycles = 0;
    end else begin
      in_acc  = (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
      out_acc = (out_ch.valid === 1'b1) && (out_ch.ready === 1'b1);
      if (cfg_we === 1'b1) lb_on = cfg_wdata;
      if (in_acc) begin
        burst = encode_byte(in_ch.data_byte, in_ch.final_byte);
        if (pin_count != 0) begin
          burst.chars = pin_chars;
          burst.count = pin_count[2:0];
        end
        for (i = 0; i < burst.count; i++) begin
          want.ch = burst.chars[8*(burst.count-1-i) +: 8];
          want.last = (i == burst.count - 1);
          pending_chars.push_back(want);
        end
      end
      if (out_acc) begin
        if (pending_chars.size() == 0) begin
          note_error($sformatf("unexpected character 0x%02h", out_ch.out_char));
        end else begin
          want = pending_chars.pop_front();
          if (out_ch.out_char !== want.ch)
            note_error($sformatf("out_char expected 0x%02h, got 0x%02h",
                                 want.ch, out_ch.out_char));
          if (out_ch.last_of_run !== want.last)
            note_error($sformatf("last_of_run expected %b, got %b (char 0x%02h)",
                                 want.last, out_ch.last_of_run, want.ch));
        end
      end
      if (in_acc || out_acc) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stalls, zero-stall stretches, one long hold-off.
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 29) == 0) rx_fast = !rx_fast;
        stall = rx_fast ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  task automatic add_row(input row_kind_t k, input logic [7:0] d, input logic f,
                         input int n, input logic [47:0] p);
    stim_row_t row;
    row.kind = k;
    row.data = d;
    row.fin = f;
    row.pin_n = n;
    row.pin = p;
    dir_rows.push_back(row);
  endtask

  // Entered at a clock edge; returns at the edge where the item is taken.
  task automatic push_byte(input logic [7:0] b, input logic f, input int n,
                           input logic [47:0] p);
    int gap;
    gap = (tx_fast || fast_left > 0) ? 0 : $urandom_range(0, 11);
    if (fast_left > 0) fast_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= f;
    pin_count        <= n;
    pin_chars        <= p;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Stop offering, wait for every expected character, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int   sent;
    int   msg_len;
    int   k;
    bit   hold_done;
    logic lb_cur;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.final_byte = 1'b0;
    pin_count = 0;
    pin_chars = '0;
    sent = 0;
    hold_done = 1'b0;
    lb_cur = 1'b0;

    // no line breaks: single-byte tails, full groups, two-byte tails
    add_row(ROW_CFG,  8'd0,  1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h00, 1'b1, 4, 48'("AA=="));
    add_row(ROW_ITEM, 8'hFF, 1'b1, 4, 48'("/w=="));
    add_row(ROW_ITEM, 8'h4D, 1'b0, 1, 48'("T"));
    add_row(ROW_ITEM, 8'h61, 1'b0, 1, 48'("W"));
    add_row(ROW_ITEM, 8'h6E, 1'b1, 2, 48'("Fu"));
    add_row(ROW_ITEM, 8'hFF, 1'b0, 1, 48'("/"));
    add_row(ROW_ITEM, 8'hFF, 1'b0, 1, 48'("/"));
    add_row(ROW_ITEM, 8'hFF, 1'b1, 2, 48'("//"));
    add_row(ROW_ITEM, 8'h00, 1'b0, 1, 48'("A"));
    add_row(ROW_ITEM, 8'h00, 1'b1, 3, 48'("AA="));
    add_row(ROW_ITEM, 8'h4D, 1'b0, 1, 48'("T"));
    add_row(ROW_ITEM, 8'h61, 1'b1, 3, 48'("WE="));
    // line breaks on: closing CR LF after a short last line
    add_row(ROW_CFG,  8'd1,  1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h00, 1'b1, 6,
            {"AA==", b64e_pkg::CHAR_CR, b64e_pkg::CHAR_LF});
    add_row(ROW_ITEM, 8'h80, 1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h7F, 1'b1, 0, '0);
    add_row(ROW_ITEM, 8'h01, 1'b0, 0, '0);
    add_row(ROW_ITEM, 8'hFE, 1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h55, 1'b1, 0, '0);
    // enable flipped in the middle of a message
    add_row(ROW_ITEM, 8'hAA, 1'b0, 0, '0);
    add_row(ROW_CFG,  8'd0,  1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h33, 1'b0, 0, '0);
    add_row(ROW_ITEM, 8'hCC, 1'b1, 0, '0);
    add_row(ROW_ITEM, 8'h12, 1'b0, 0, '0);
    add_row(ROW_CFG,  8'd1,  1'b0, 0, '0);
    add_row(ROW_ITEM, 8'h34, 1'b1, 0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain();
        write_cfg(dir_rows[r].data[0]);
        lb_cur = dir_rows[r].data[0];
      end else begin
        push_byte(dir_rows[r].data, dir_rows[r].fin, dir_rows[r].pin_n,
                  dir_rows[r].pin);
      end
    end

    // random messages; long ones may cross line breaks
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        lb_cur = !lb_cur;
        write_cfg(lb_cur);
      end
      msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 130)
                                            : $urandom_range(1, 9);
      if (msg_len > RANDOM_ITEMS - sent) msg_len = RANDOM_ITEMS - sent;
      tx_fast = ($urandom_range(0, 3) == 0);
      for (k = 0; k < msg_len; k++) begin
        if (!hold_done && sent >= 100) begin
          // receiver goes quiet while bytes keep coming
          hold_req = 1'b1;
          fast_left = 40;
          hold_done = 1'b1;
        end
        if (k > 0 && $urandom_range(0, 39) == 0) begin
          drain();
          lb_cur = !lb_cur;
          write_cfg(lb_cur);
        end
        push_byte(8'($urandom_range(0, 255)), k == msg_len - 1, 0, '0);
        sent++;
      end
    end

    drain();
    if (pending_chars.size() != 0)
      note_error($sformatf("%0d expected characters never arrived",
                           pending_chars.size()));
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
